/* hw/rtl/dual_tone_cadence_generator_defines.svh */
// Assertion macros shared by the dual-tone cadence generator RTL.
`ifndef DUAL_TONE_CADENCE_GENERATOR_DEFINES_SVH
`define DUAL_TONE_CADENCE_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define DTCG_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dtcg: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define DTCG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dtcg: next-cycle check failed");

`endif

/* hw/rtl/dtcg_pkg.sv */
// Constants, register codes and the sine table function for the dual-tone cadence generator.
package dtcg_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int STEP_W      = 32;
	localparam int CADENCE_W   = 20;
	localparam int AMP_W       = 15;
	localparam int SAMPLE_W    = 16;
	localparam int SUM_W       = SAMPLE_W + 1;
	localparam int PROD_W      = 32;

	localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(6553);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PHASE_STEP_A   = 3'd0,
		REG_PHASE_STEP_B   = 3'd1,
		REG_CONTINUOUS     = 3'd2,
		REG_ON_SAMPLES     = 3'd3,
		REG_OFF_SAMPLES    = 3'd4,
		REG_AMPLITUDE      = 3'd5
	} cfg_reg_t;

	// Q30 Taylor coefficients of sin(pi/2 * z).
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] SC1     = 64'd1686629713;
	localparam logic [63:0] SC3     = 64'd693598642;
	localparam logic [63:0] SC5     = 64'd85569306;
	localparam logic [63:0] SC7     = 64'd5026995;
	localparam logic [63:0] SC9     = 64'd172272;
	localparam logic [63:0] FULL_SCALE = 64'd32767;

	// Sine value for a Q32 turn fraction; evaluated only at elaboration to fill the table.
	function automatic logic signed [SAMPLE_W-1:0] sine_value(input logic [63:0] turn);
		logic [1:0]  quad;
		logic [63:0] r;
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		quad = turn[31:30];
		r = {34'd0, turn[29:0]};
		z = quad[0] ? (Q30_ONE - r) : r;
		z2 = (z * z) >> 30;
		t = SC9;
		t = SC7 - ((z2 * t) >> 30);
		t = SC5 - ((z2 * t) >> 30);
		t = SC3 - ((z2 * t) >> 30);
		t = SC1 - ((z2 * t) >> 30);
		s = (z * t) >> 30;
		v = (s * FULL_SCALE + (Q30_ONE >> 1)) >> 30;
		if (v > FULL_SCALE) begin
			v = FULL_SCALE;
		end
		return quad[1] ? -$signed(v[SAMPLE_W-1:0]) : $signed(v[SAMPLE_W-1:0]);
	endfunction

endpackage

/* hw/rtl/dual_tone_cadence_generator.sv */
// Dual-tone cadence generator: two phase-accumulator oscillators, mixer and on/off cadence.
//
// Usage: each transaction on the input channel (in_valid/in_ready, field tone_enable) is one
// sample tick and produces exactly one transaction on the output channel
// (out_valid/out_ready, fields sample_out and tone_sounding), in order.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one register
// per transaction and is always ready; registers 0..5 are phase_step_a, phase_step_b,
// continuous_mode, on_samples, off_samples and amplitude, other indexes are ignored.
// Write configuration only while no sample is in flight.
// A sample is offered on the output after passing three registers (sine table read,
// mix multiply, truncate).
// Throughput: one tick per cycle while the output is not stalled.
// When the output is stalled the whole three-stage pipeline holds and in_ready drops
// in the same cycle; in_ready follows out_ready while the output register is full.
// Reset clears the phases, the cadence counter and all pipeline valids, and loads the
// register defaults (continuous mode, amplitude 6553, everything else zero).
// The sine table is a constant ROM of SINE_TABLE_DEPTH entries read on two ports.
module dual_tone_cadence_generator
	import dtcg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int PHASE_BITS       = 32,
	parameter int COUNT_BITS       = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       tone_enable,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic                       tone_sounding
);

	`include "dual_tone_cadence_generator_defines.svh"

	localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH);
	localparam int SCALE_W = PHASE_BITS + ADDR_W;
	localparam int CMP_W   = (COUNT_BITS > CADENCE_W) ? COUNT_BITS : CADENCE_W;

	// Configuration registers
	logic [STEP_W-1:0]    phase_step_a_q;
	logic [STEP_W-1:0]    phase_step_b_q;
	logic                 continuous_q;
	logic [CADENCE_W-1:0] on_samples_q;
	logic [CADENCE_W-1:0] off_samples_q;
	logic [AMP_W-1:0]     amplitude_q;

	// Oscillator and cadence state
	logic [PHASE_BITS-1:0] phase_acc_a_q;
	logic [PHASE_BITS-1:0] phase_acc_b_q;
	logic [COUNT_BITS-1:0] cadence_count_q;
	logic                  in_silence_q;

	// Pipeline
	logic                       valid_s1;
	logic                       play_s1;
	logic                       b_en_s1;
	logic signed [SAMPLE_W-1:0] sine_a_s1;
	logic signed [SAMPLE_W-1:0] sine_b_s1;
	logic                       valid_s2;
	logic                       play_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       tone_sounding_q;

	logic signed [SAMPLE_W-1:0] sine_rom [SINE_TABLE_DEPTH];

	logic                  advance;
	logic                  accept;
	logic                  clear_run;
	logic                  play;
	logic [COUNT_BITS-1:0] count_inc;
	logic                  on_done;
	logic                  off_done;
	logic [SCALE_W-1:0]    scaled_a;
	logic [SCALE_W-1:0]    scaled_b;
	logic [ADDR_W-1:0]     idx_a;
	logic [ADDR_W-1:0]     idx_b;
	logic signed [SUM_W-1:0]  mix_sum;
	logic signed [PROD_W-1:0] mix_prod;
	logic signed [PROD_W-1:0] prod_round;
	logic                     run_cleared;

	// Constant sine table, one entry per generate step.
	for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
		localparam logic [63:0] TURN = (64'(g) << 32) / SINE_TABLE_DEPTH;
		assign sine_rom[g] = sine_value(TURN);
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_a_q <= '0;
			phase_step_b_q <= '0;
			continuous_q   <= 1'b1;
			on_samples_q   <= '0;
			off_samples_q  <= '0;
			amplitude_q    <= AMP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PHASE_STEP_A: phase_step_a_q <= cfg_data[STEP_W-1:0];
				REG_PHASE_STEP_B: phase_step_b_q <= cfg_data[STEP_W-1:0];
				REG_CONTINUOUS:   continuous_q   <= cfg_data[0];
				REG_ON_SAMPLES:   on_samples_q   <= cfg_data[CADENCE_W-1:0];
				REG_OFF_SAMPLES:  off_samples_q  <= cfg_data[CADENCE_W-1:0];
				REG_AMPLITUDE:    amplitude_q    <= cfg_data[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together whenever the output register can take a sample.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;
	assign accept   = in_valid && advance;

	always_comb begin
		clear_run = !tone_enable || (!continuous_q && (on_samples_q == '0));
		play      = !clear_run && (continuous_q || !in_silence_q);
		count_inc = (cadence_count_q == '1) ? cadence_count_q : cadence_count_q + 1'b1;
		on_done   = CMP_W'(count_inc) >= CMP_W'(on_samples_q);
		off_done  = CMP_W'(count_inc) >= CMP_W'(off_samples_q);
	end

	// Table index is (phase * depth) >> PHASE_BITS, which is a plain shift for a power of two.
	assign scaled_a = SCALE_W'(phase_acc_a_q) * SCALE_W'(SINE_TABLE_DEPTH);
	assign scaled_b = SCALE_W'(phase_acc_b_q) * SCALE_W'(SINE_TABLE_DEPTH);
	assign idx_a    = scaled_a[SCALE_W-1:PHASE_BITS];
	assign idx_b    = scaled_b[SCALE_W-1:PHASE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_a_q   <= '0;
			phase_acc_b_q   <= '0;
			cadence_count_q <= '0;
			in_silence_q    <= 1'b0;
		end else if (accept) begin
			if (play) begin
				phase_acc_a_q <= phase_acc_a_q + phase_step_a_q[PHASE_BITS-1:0];
				phase_acc_b_q <= phase_acc_b_q + phase_step_b_q[PHASE_BITS-1:0];
			end
			if (clear_run) begin
				phase_acc_a_q   <= '0;
				phase_acc_b_q   <= '0;
				cadence_count_q <= '0;
				in_silence_q    <= 1'b0;
			end else if (continuous_q) begin
				cadence_count_q <= '0;
				in_silence_q    <= 1'b0;
			end else if (!in_silence_q) begin
				if (on_done) begin
					cadence_count_q <= '0;
					in_silence_q    <= (off_samples_q != '0);
				end else begin
					cadence_count_q <= count_inc;
				end
			end else begin
				if (off_done) begin
					cadence_count_q <= '0;
					in_silence_q    <= 1'b0;
				end else begin
					cadence_count_q <= count_inc;
				end
			end
		end
	end

	// Stage 1: registered table reads on two ports.
	always_ff @(posedge clk) begin
		if (advance) begin
			sine_a_s1 <= sine_rom[idx_a];
			sine_b_s1 <= sine_rom[idx_b];
			play_s1   <= play;
			b_en_s1   <= (phase_step_b_q != '0);
		end
	end

	// Stage 2: mix and scale. A silent tick is registered as zero.
	always_comb begin
		mix_sum  = SUM_W'(sine_a_s1) + (b_en_s1 ? SUM_W'(sine_b_s1) : SUM_W'(0));
		mix_prod = PROD_W'(mix_sum) * PROD_W'($signed({1'b0, amplitude_q}));
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s2 <= play_s1 ? mix_prod : '0;
			play_s2 <= play_s1;
		end
	end

	// Output stage: divide by 65536 rounding toward zero.
	assign prod_round = prod_s2 + (prod_s2[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_q        <= prod_round[PROD_W-1:PROD_W-SAMPLE_W];
			tone_sounding_q <= play_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign sample_out    = sample_q;
	assign tone_sounding = tone_sounding_q;

	assign run_cleared = (phase_acc_a_q == '0) && (phase_acc_b_q == '0) &&
		(cadence_count_q == '0) && !in_silence_q;

	`DTCG_ASSERT_IMPL(a_silent_is_zero, out_valid && !tone_sounding, sample_out == '0)
	`DTCG_ASSERT_NEXT(a_disable_clears, accept && !tone_enable, run_cleared)
	`DTCG_ASSERT_IMPL(a_stall_holds_input, out_valid_q && !out_ready, !accept && !in_ready)

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the dual-tone cadence generator with its own sample predictor.
module tb_top;
	import dtcg_pkg::*;

	localparam int TONE_DEPTH = 1024;
	localparam int TONE_IDX_W = $clog2(TONE_DEPTH);
	localparam int PHASE_W    = 32;
	localparam int CNT_W      = 20;
	localparam int LATENCY    = 3;
	localparam int CLK_HALF   = 4;
	localparam int MAX_GAP    = 40;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = CFG_INDEX_W'(6);
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = CFG_INDEX_W'(7);

	localparam logic [STEP_W-1:0]    STEP_TOP = '1;
	localparam logic [CADENCE_W-1:0] LEN_TOP  = '1;
	localparam logic [AMP_W-1:0]     GAIN_TOP = '1;
	localparam logic [CNT_W-1:0]     CNT_TOP  = '1;

	// Q30 Taylor series of sin(pi/2 * z).
	localparam logic [63:0] Q30_UNIT = 64'd1073741824;
	localparam logic [63:0] TAY_C1   = 64'd1686629713;
	localparam logic [63:0] TAY_C3   = 64'd693598642;
	localparam logic [63:0] TAY_C5   = 64'd85569306;
	localparam logic [63:0] TAY_C7   = 64'd5026995;
	localparam logic [63:0] TAY_C9   = 64'd172272;
	localparam logic [63:0] PEAK     = 64'd32767;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       sounding;
	} tone_out_t;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       cfg_valid   = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_W-1:0]     cfg_index   = '0;
	logic [CFG_DATA_W-1:0]      cfg_data    = '0;
	logic                       in_valid    = 1'b0;
	logic                       in_ready;
	logic                       tone_enable = 1'b0;
	logic                       out_valid;
	logic                       out_ready   = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       tone_sounding;

	// Predictor copy of the registers and the running state.
	logic [STEP_W-1:0]    step_a    = '0;
	logic [STEP_W-1:0]    step_b    = '0;
	logic                 cont_mode = 1'b1;
	logic [CADENCE_W-1:0] on_len    = '0;
	logic [CADENCE_W-1:0] off_len   = '0;
	logic [AMP_W-1:0]     gain      = AMP_RESET;
	logic [PHASE_W-1:0]   ph_a      = '0;
	logic [PHASE_W-1:0]   ph_b      = '0;
	logic [CNT_W-1:0]     cad_cnt   = '0;
	logic                 silent    = 1'b0;

	logic signed [SAMPLE_W-1:0] sine_rom [TONE_DEPTH];
	tone_out_t tone_samples_due [$];

	int mismatch_count = 0;
	int idle_in_pct    = 0;
	int stall_out_pct  = 0;
	int hold_off       = 0;

	dual_tone_cadence_generator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.tone_enable  (tone_enable),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_out   (sample_out),
		.tone_sounding(tone_sounding)
	);

	always #CLK_HALF clk = ~clk;

	initial begin : sine_fill
		logic [63:0] f;
		logic [63:0] r;
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		logic [1:0]  quad;
		for (int i = 0; i < TONE_DEPTH; i++) begin
			f = (64'(i) << 32) / TONE_DEPTH;
			quad = f[31:30];
			r = {34'd0, f[29:0]};
			z = quad[0] ? (Q30_UNIT - r) : r;
			z2 = (z * z) >> 30;
			t = TAY_C9;
			t = TAY_C7 - ((z2 * t) >> 30);
			t = TAY_C5 - ((z2 * t) >> 30);
			t = TAY_C3 - ((z2 * t) >> 30);
			t = TAY_C1 - ((z2 * t) >> 30);
			s = (z * t) >> 30;
			v = (s * PEAK + (Q30_UNIT >> 1)) >> 30;
			if (v > PEAK) begin
				v = PEAK;
			end
			sine_rom[i] = quad[1] ? -SAMPLE_W'(v) : SAMPLE_W'(v);
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] sine_at(input logic [PHASE_W-1:0] ph);
		return sine_rom[TONE_IDX_W'((64'(ph) * TONE_DEPTH) >> PHASE_W)];
	endfunction

	// Reads both oscillators, mixes and scales, then advances the phases.
	function automatic logic signed [SAMPLE_W-1:0] mix_tone();
		int a;
		int b;
		int p;
		a = sine_at(ph_a);
		b = (step_b != '0) ? sine_at(ph_b) : 0;
		p = (a + b) * int'(gain);
		ph_a = ph_a + step_a;
		ph_b = ph_b + step_b;
		return SAMPLE_W'(p / 65536);
	endfunction

	function automatic tone_out_t next_tone_sample(input logic en);
		tone_out_t    res;
		logic [CNT_W:0] nxt;
		res.sample = '0;
		res.sounding = 1'b0;
		if (!en || (!cont_mode && on_len == '0)) begin
			ph_a = '0;
			ph_b = '0;
			cad_cnt = '0;
			silent = 1'b0;
		end else if (cont_mode) begin
			cad_cnt = '0;
			silent = 1'b0;
			res.sample = mix_tone();
			res.sounding = 1'b1;
		end else begin
			nxt = (cad_cnt < CNT_TOP) ? cad_cnt + 1'b1 : CNT_TOP;
			if (!silent) begin
				res.sample = mix_tone();
				res.sounding = 1'b1;
				if (nxt >= on_len) begin
					cad_cnt = '0;
					silent = (off_len != '0);
				end else begin
					cad_cnt = nxt[CNT_W-1:0];
				end
			end else if (nxt >= off_len) begin
				cad_cnt = '0;
				silent = 1'b0;
			end else begin
				cad_cnt = nxt[CNT_W-1:0];
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// All driving tasks start and return just after a falling edge.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PHASE_STEP_A: step_a = data;
			REG_PHASE_STEP_B: step_b = data;
			REG_CONTINUOUS:   cont_mode = data[0];
			REG_ON_SAMPLES:   on_len = data[CADENCE_W-1:0];
			REG_OFF_SAMPLES:  off_len = data[CADENCE_W-1:0];
			REG_AMPLITUDE:    gain = data[AMP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic cfg_idle();
		cfg_valid <= 1'b0;
	endtask

	task automatic send_tick(input logic en);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_in_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		tone_enable <= en;
		do @(posedge clk); while (!in_ready);
		tone_samples_due.push_back(next_tone_sample(en));
		@(negedge clk);
	endtask

	// Stops offering ticks and waits until every predicted sample has come out.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (tone_samples_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	// Unused upper bits of the mode, length and amplitude writes carry random junk that the block must drop.
	task automatic load_settings(input logic [STEP_W-1:0] sa, input logic [STEP_W-1:0] sb,
			input logic cont, input logic [CADENCE_W-1:0] on_n,
			input logic [CADENCE_W-1:0] off_n, input logic [AMP_W-1:0] amp);
		quiesce();
		write_reg(REG_PHASE_STEP_A, sa);
		write_reg(REG_PHASE_STEP_B, sb);
		write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
		write_reg(REG_CONTINUOUS, ($urandom() & ~32'h1) | 32'(cont));
		write_reg(REG_ON_SAMPLES, ($urandom() & ~32'hF_FFFF) | 32'(on_n));
		write_reg(REG_OFF_SAMPLES, ($urandom() & ~32'hF_FFFF) | 32'(off_n));
		write_reg(REG_AMPLITUDE, ($urandom() & ~32'h7FFF) | 32'(amp));
		cfg_idle();
	endtask

	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off--;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_out_pct);
		end
	end

	always @(posedge clk) begin
		tone_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (tone_samples_due.size() == 0) begin
				report_mismatch($sformatf("unexpected sample %0d sounding %0b",
					sample_out, tone_sounding));
			end else begin
				want = tone_samples_due.pop_front();
				if (sample_out !== want.sample) begin
					report_mismatch($sformatf("sample_out %0d, predicted %0d",
						sample_out, want.sample));
				end
				if (tone_sounding !== want.sounding) begin
					report_mismatch($sformatf("tone_sounding %0b, predicted %0b",
						tone_sounding, want.sounding));
				end
			end
		end
	end

	task automatic test_defaults();
		send_tick(1'b1);
		send_tick(1'b0);
		quiesce();
		// Only the step is written, so the reset amplitude applies.
		write_reg(REG_PHASE_STEP_A, 32'h0123_4567);
		cfg_idle();
		repeat (3) send_tick(1'b1);
	endtask

	task automatic test_continuous();
		load_settings(STEP_TOP, '0, 1'b1, '0, '0, GAIN_TOP);
		repeat (2) send_tick(1'b1);
		// Quarter-turn steps land on the sine peaks, giving the largest sums.
		load_settings(32'h4000_0000, 32'h4000_0000, 1'b1, LEN_TOP, '0, GAIN_TOP);
		repeat (4) send_tick(1'b1);
		load_settings(32'h0290_0000, STEP_TOP, 1'b1, '0, LEN_TOP, '0);
		repeat (2) send_tick(1'b1);
	endtask

	task automatic test_cadence();
		load_settings(32'h0290_0000, 32'h0131_0000, 1'b0, 20'd2, 20'd3, 15'd20000);
		repeat (6) send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		load_settings(32'h0290_0000, 32'h0131_0000, 1'b0, '0, 20'd3, 15'd20000);
		send_tick(1'b1);
		// With no off period the tone never goes silent.
		load_settings(32'h0290_0000, '0, 1'b0, 20'd3, '0, GAIN_TOP);
		repeat (3) send_tick(1'b1);
		load_settings(32'h0290_0000, 32'h0131_0000, 1'b0, 20'd2, 20'd4, GAIN_TOP);
		repeat (3) send_tick(1'b1);
		// Clearing the off length in the middle of silence still costs one silent tick.
		quiesce();
		write_reg(REG_OFF_SAMPLES, '0);
		cfg_idle();
		repeat (2) send_tick(1'b1);
		load_settings(STEP_TOP, STEP_TOP, 1'b0, LEN_TOP, LEN_TOP, GAIN_TOP);
		send_tick(1'b1);
	endtask

	task automatic test_backpressure();
		load_settings($urandom(), $urandom(), 1'b0, 20'd5, 20'd2, GAIN_TOP);
		idle_in_pct = 0;
		stall_out_pct = 0;
		hold_off = 150;
		repeat (40) send_tick(1'b1);
		quiesce();
	endtask

	task automatic test_random();
		logic [STEP_W-1:0]    sa;
		logic [STEP_W-1:0]    sb;
		logic [CADENCE_W-1:0] on_n;
		logic [CADENCE_W-1:0] off_n;
		logic [AMP_W-1:0]     amp;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
				1: begin idle_in_pct = 60; stall_out_pct = 0;  end
				2: begin idle_in_pct = 0;  stall_out_pct = 60; end
				default: begin idle_in_pct = 10; stall_out_pct = 10; end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				case ($urandom_range(3))
					0: sa = '0;
					1: sa = STEP_TOP;
					default: sa = $urandom();
				endcase
				case ($urandom_range(3))
					0: sb = '0;
					1: sb = STEP_TOP;
					default: sb = $urandom();
				endcase
				case ($urandom_range(9))
					0: on_n = '0;
					1: on_n = LEN_TOP;
					2: on_n = CADENCE_W'($urandom_range(9, 60));
					default: on_n = CADENCE_W'($urandom_range(1, 8));
				endcase
				case ($urandom_range(9))
					0, 1: off_n = '0;
					2: off_n = LEN_TOP;
					3: off_n = CADENCE_W'($urandom_range(9, 60));
					default: off_n = CADENCE_W'($urandom_range(1, 8));
				endcase
				case ($urandom_range(3))
					0: amp = '0;
					1: amp = GAIN_TOP;
					default: amp = AMP_W'($urandom());
				endcase
				load_settings(sa, sb, 1'($urandom_range(1)), on_n, off_n, amp);
				repeat (50) send_tick($urandom_range(99) < 92);
			end
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_defaults();
		test_continuous();
		test_cadence();
		test_backpressure();
		test_random();
		idle_in_pct = 0;
		stall_out_pct = 0;
		quiesce();
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
